// ===== hdl/double_hash_filter_table_core_assert.svh =====
// Assertion macros for the double hash filter table core.
// Depends on nothing; included by the checker file.
`ifndef DOUBLE_HASH_FILTER_TABLE_CORE_ASSERT_SVH
`define DOUBLE_HASH_FILTER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication under an active low reset.
`define DHFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active low reset.
`define DHFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dhft_pkg.sv =====
// Shared types, codes and constants of the double hash filter table core.
// Depends on nothing.
`default_nettype none

package dhft_pkg;

    localparam int MAX_LOG2_DEF = 12;
    localparam int ROUTES_W     = 13;
    localparam int CFG_ADDR_W   = 3;

    localparam logic [ROUTES_W-1:0] ROUTES_MAX    = 13'h1FFF;
    localparam logic [3:0]          SIZE_LOG2_RST = 4'd12;
    localparam logic                REG_SIZE_LOG2 = 1'b0;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_TOMB  = 2'd1,
        KIND_USED  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_LOOP      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        WR_ZERO  = 3'd0,
        WR_STORE = 3'd1,
        WR_INC   = 3'd2,
        WR_DEC   = 3'd3,
        WR_FINAL = 3'd4
    } t_wr;

    typedef enum logic [1:0] {
        SLOT_ZERO  = 2'd0,
        SLOT_IDX   = 2'd1,
        SLOT_MATCH = 2'd2
    } t_slot_sel;

    typedef struct packed {
        logic        kind;
        logic [15:0] owner_id;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [11:0] start_index;
        logic [11:0] step;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] slot;
    } t_out_item;

    typedef struct packed {
        t_kind               kind;
        logic [15:0]         owner;
        logic [ROUTES_W-1:0] routes;
        logic [63:0]         addr_high;
        logic [63:0]         addr_low;
    } t_rec;

    typedef struct packed {
        logic      load;
        logic      clr;
        logic      adv;
        logic      rewind;
        logic      keep_match;
        logic      wr;
        t_wr       wr_mode;
        logic      out_load;
        t_status   out_status;
        t_slot_sel out_slot;
    } t_cmd;

    typedef struct packed {
        logic used;
        logic empty;
        logic match;
        logic wrap;
        logic next_is_match;
        logic at_start;
        logic clr_last;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/dhft_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`default_nettype none

module dhft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/dhft_ctrl.sv =====
// Controller of the double hash filter table: clear pass, probe, re-walk, finish.
// Depends on dhft_pkg; drives the datapath through t_cmd, reads t_stat.
`default_nettype none

module dhft_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_kind,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire dhft_pkg::t_stat i_stat,
    output dhft_pkg::t_cmd      o_cmd
);
    import dhft_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_INS   = 6'b000100,
        S_REM   = 6'b001000,
        S_WALK  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   busy;
    t_cmd   cmd;

    assign busy = r_out_valid && !i_out_ready;

    always_comb begin
        n_state        = r_state;
        cmd.load       = 1'b0;
        cmd.clr        = 1'b0;
        cmd.adv        = 1'b0;
        cmd.rewind     = 1'b0;
        cmd.keep_match = 1'b0;
        cmd.wr         = 1'b0;
        cmd.wr_mode    = WR_ZERO;
        cmd.out_load   = 1'b0;
        cmd.out_status = ST_DONE;
        cmd.out_slot   = SLOT_ZERO;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr     = 1'b1;
                cmd.wr      = 1'b1;
                cmd.wr_mode = WR_ZERO;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = (i_kind == OP_REMOVE) ? S_REM : S_INS;
                end
            end
            S_INS: begin
                priority if (!i_stat.used) begin
                    if (!busy) begin
                        cmd.wr         = 1'b1;
                        cmd.wr_mode    = WR_STORE;
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_DONE;
                        cmd.out_slot   = SLOT_IDX;
                        n_state        = S_IDLE;
                    end
                end else if (i_stat.wrap) begin
                    if (!busy) begin
                        cmd.wr         = 1'b1;
                        cmd.wr_mode    = WR_INC;
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_FULL;
                        n_state        = S_IDLE;
                    end
                end else begin
                    cmd.wr      = 1'b1;
                    cmd.wr_mode = WR_INC;
                    cmd.adv     = 1'b1;
                end
            end
            S_REM: begin
                priority if (i_stat.match) begin
                    cmd.keep_match = 1'b1;
                    if (i_stat.at_start) begin
                        n_state = S_FIN;
                    end else begin
                        cmd.rewind = 1'b1;
                        n_state    = S_WALK;
                    end
                end else if (i_stat.empty) begin
                    if (!busy) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_NOT_FOUND;
                        n_state        = S_IDLE;
                    end
                end else if (i_stat.wrap) begin
                    if (!busy) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_LOOP;
                        n_state        = S_IDLE;
                    end
                end else begin
                    cmd.adv = 1'b1;
                end
            end
            S_WALK: begin
                cmd.wr      = 1'b1;
                cmd.wr_mode = WR_DEC;
                if (i_stat.next_is_match) begin
                    n_state = S_FIN;
                end else begin
                    cmd.adv = 1'b1;
                end
            end
            S_FIN: begin
                if (!busy) begin
                    cmd.wr         = 1'b1;
                    cmd.wr_mode    = WR_FINAL;
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_DONE;
                    cmd.out_slot   = SLOT_MATCH;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

// ===== hdl/dhft_dp.sv =====
// Datapath of the double hash filter table: slot memory, probe index, result beat.
// Depends on dhft_pkg and dhft_ram; commanded by dhft_ctrl.
`default_nettype none

module dhft_dp #(
    parameter int MAX_LOG2 = dhft_pkg::MAX_LOG2_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dhft_pkg::t_in_item   i_in,
    input  wire logic [MAX_LOG2-1:0]  i_mask,
    input  wire dhft_pkg::t_cmd       i_cmd,
    output dhft_pkg::t_stat           o_stat,
    output dhft_pkg::t_out_item       o_out
);
    import dhft_pkg::*;

    localparam int IW    = MAX_LOG2;
    localparam int DEPTH = 1 << MAX_LOG2;
    localparam int RW    = $bits(t_rec);

    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_start;
    logic [IW-1:0]       r_step;
    logic [IW-1:0]       r_match;
    logic [ROUTES_W-1:0] r_match_routes;
    logic [15:0]         r_owner;
    logic [63:0]         r_addr_high;
    logic [63:0]         r_addr_low;
    t_out_item           r_out;

    logic [IW+11:0]      start_wide;
    logic [IW+11:0]      step_wide;
    logic [IW-1:0]       in_start;
    logic [IW-1:0]       in_step;
    logic [IW-1:0]       idx_next;
    logic [IW-1:0]       slot_idx;
    logic [IW+11:0]      slot_wide;

    logic                ram_re;
    logic [IW-1:0]       ram_raddr;
    logic [IW-1:0]       ram_waddr;
    logic [RW-1:0]       ram_rdata;
    t_rec                rd_rec;
    t_rec                wr_rec;
    logic [ROUTES_W-1:0] routes_dec;

    assign start_wide = {{IW{1'b0}}, i_in.start_index};
    assign step_wide  = {{IW{1'b0}}, i_in.step};
    assign in_start   = start_wide[IW-1:0] & i_mask;
    assign in_step    = step_wide[IW-1:0] & i_mask;
    assign idx_next   = (r_idx + r_step) & i_mask;
    assign rd_rec     = ram_rdata;

    always_comb begin
        ram_re    = i_cmd.load || i_cmd.adv || i_cmd.rewind;
        ram_raddr = r_start;
        priority if (i_cmd.load) begin
            ram_raddr = in_start;
        end else if (i_cmd.adv) begin
            ram_raddr = idx_next;
        end else begin
            ram_raddr = r_start;
        end
    end

    assign routes_dec = (rd_rec.routes != '0) ? rd_rec.routes - 1'b1 : '0;

    always_comb begin
        wr_rec    = rd_rec;
        ram_waddr = r_idx;
        unique case (i_cmd.wr_mode)
            WR_ZERO: begin
                wr_rec.kind      = KIND_EMPTY;
                wr_rec.owner     = '0;
                wr_rec.routes    = '0;
                wr_rec.addr_high = '0;
                wr_rec.addr_low  = '0;
            end
            WR_STORE: begin
                wr_rec.kind      = KIND_USED;
                wr_rec.owner     = r_owner;
                wr_rec.addr_high = r_addr_high;
                wr_rec.addr_low  = r_addr_low;
            end
            WR_INC: begin
                if (rd_rec.routes != ROUTES_MAX) begin
                    wr_rec.routes = rd_rec.routes + 1'b1;
                end
            end
            WR_DEC: begin
                wr_rec.routes = routes_dec;
                if (routes_dec == '0 && rd_rec.kind == KIND_TOMB) begin
                    wr_rec.kind = KIND_EMPTY;
                end
            end
            WR_FINAL: begin
                wr_rec.kind      = (r_match_routes == '0) ? KIND_EMPTY : KIND_TOMB;
                wr_rec.owner     = r_owner;
                wr_rec.routes    = r_match_routes;
                wr_rec.addr_high = r_addr_high;
                wr_rec.addr_low  = r_addr_low;
                ram_waddr        = r_match;
            end
            default: begin
                wr_rec = rd_rec;
            end
        endcase
    end

    dhft_ram #(
        .WIDTH(RW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr),
        .i_waddr(ram_waddr),
        .i_wdata(wr_rec),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        priority if (i_cmd.load) begin
            n_idx = in_start;
        end else if (i_cmd.clr) begin
            n_idx = r_idx + 1'b1;
        end else if (i_cmd.adv) begin
            n_idx = idx_next;
        end else if (i_cmd.rewind) begin
            n_idx = r_start;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    always_comb begin
        unique case (i_cmd.out_slot)
            SLOT_IDX:   slot_idx = r_idx;
            SLOT_MATCH: slot_idx = r_match;
            default:    slot_idx = '0;
        endcase
    end

    assign slot_wide = {12'd0, slot_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start     <= in_start;
            r_step      <= in_step;
            r_owner     <= i_in.owner_id;
            r_addr_high <= i_in.addr_high;
            r_addr_low  <= i_in.addr_low;
        end
        if (i_cmd.keep_match) begin
            r_match        <= r_idx;
            r_match_routes <= rd_rec.routes;
        end
        if (i_cmd.out_load) begin
            r_out.status <= i_cmd.out_status;
            r_out.slot   <= slot_wide[11:0];
        end
    end

    always_comb begin
        o_stat.used          = rd_rec.kind == KIND_USED;
        o_stat.empty         = rd_rec.kind == KIND_EMPTY;
        o_stat.match         = (rd_rec.kind == KIND_USED) && (rd_rec.owner == r_owner) &&
                               (rd_rec.addr_high == r_addr_high) &&
                               (rd_rec.addr_low == r_addr_low);
        o_stat.wrap          = idx_next == r_start;
        o_stat.next_is_match = idx_next == r_match;
        o_stat.at_start      = r_idx == r_start;
        o_stat.clr_last      = &r_idx;
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ===== hdl/double_hash_filter_table_core.sv =====
// Channel   Dir  Handshake                  Payload
// in        in   i_in_valid / o_in_ready    i_in  (t_in_item)
// out       out  o_out_valid / i_out_ready  o_out (t_out_item)
// cfg       in   psel, penable, pwrite      paddr, pwdata, prdata (size_log2)
//
// One item at a time; one slot memory access per cycle sets the pace.
// Insert probes from the start index to a free slot (or a loop: full), bumping routes
// of used slots; remove probes to a match, an empty slot or a loop, then re-walks to it.
// After reset a clearing pass over all 2^MAX_LOG2 slots runs; no beat is taken meanwhile.
// A result held by a stalled consumer holds the last step until the beat is taken.
// Depends on dhft_pkg, dhft_ctrl, dhft_dp and dhft_ram.
`default_nettype none

module double_hash_filter_table_core #(
    parameter int MAX_LOG2 = dhft_pkg::MAX_LOG2_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire dhft_pkg::t_in_item            i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output dhft_pkg::t_out_item                o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dhft_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import dhft_pkg::*;

    logic [3:0]          r_size_log2;
    logic [4:0]          lg_ext;
    logic [4:0]          lg_eff;
    logic [MAX_LOG2-1:0] mask;
    t_cmd                cmd;
    t_stat               stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= SIZE_LOG2_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SIZE_LOG2) begin
            r_size_log2 <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIZE_LOG2) ? {28'd0, r_size_log2} : 32'd0;

    assign lg_ext = {1'b0, r_size_log2};

    always_comb begin
        priority if (lg_ext < 5'd1) begin
            lg_eff = 5'd1;
        end else if (lg_ext > 5'(MAX_LOG2)) begin
            lg_eff = 5'(MAX_LOG2);
        end else begin
            lg_eff = lg_ext;
        end
    end

    always_comb begin
        for (int b = 0; b < MAX_LOG2; b++) begin
            mask[b] = 5'(b) < lg_eff;
        end
    end

    dhft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in.kind),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dhft_dp #(
        .MAX_LOG2(MAX_LOG2)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_mask (mask),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_out  (o_out)
    );

endmodule

`default_nettype wire

// ===== hdl/dhft_checker.sv =====
// Port-level checks on the double hash filter table core, bound to the top level.
// Depends on dhft_pkg and double_hash_filter_table_core_assert.svh.
`default_nettype none

`include "double_hash_filter_table_core_assert.svh"

module dhft_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire dhft_pkg::t_out_item             o_out,
    input wire logic [31:0]                     prdata,
    input wire logic                            pready
);
    import dhft_pkg::*;

    `DHFT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result beat changed while stalled")

    `DHFT_ASSERT_NOW(a_slot_zero, i_clk, i_rst_n, o_out_valid && (o_out.status != ST_DONE), o_out.slot == 12'd0, "slot nonzero on failed operation")

    `DHFT_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second beat taken while busy")

    `DHFT_ASSERT_NOW(a_cfg_port, i_clk, i_rst_n, 1'b1, pready && (prdata[31:4] == 28'd0), "config port read data or ready wrong")

endmodule

bind double_hash_filter_table_core dhft_checker u_dhft_checker (.*);

`default_nettype wire
